/* design/tlpw_pkg.sv */
// Shared types and codes for the two-level page walker.
`default_nettype none

package tlpw_pkg;

  // Input item selector (travels in s_axis_tuser)
  localparam logic OP_REQUEST  = 1'b0;
  localparam logic OP_MEM_WORD = 1'b1;

  // Result item kind (travels in m_axis_tuser)
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DIR   = 2'd1;
  localparam logic [1:0] FAULT_TABLE = 2'd2;

  // Configuration register indexes
  localparam logic REG_PAGING_ON      = 1'b0;
  localparam logic REG_DIR_BASE_FRAME = 1'b1;

  // Walk phase, one-hot
  typedef enum logic [2:0] {
    PHASE_IDLE  = 3'b001,
    PHASE_DIR   = 3'b010,
    PHASE_TABLE = 3'b100
  } phase_t;

endpackage

`default_nettype wire

/* design/two_level_page_walker_top.sv */
// Two-level page walker: translates linear addresses through a two-level page table.
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: linear_address, mem_word
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser: kind; tdata: read_address,
//                                               physical_address, fault
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// Cycles: each input item is decoded and its result item (if any) lands in the output
// register on the edge that accepts it, so one item per cycle is sustained.
// The output register is the only stage; s_axis_tready drops only while a result waits
// and m_axis_tready is low. cfg_ready is always high.
// Reset (rst, synchronous) clears the walk phase, the pending address bits, both
// configuration registers and the output valid.

module two_level_page_walker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [19:0] cfg_data,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] linear_address, [63:32] mem_word
  input  wire logic        s_axis_tuser,   // [0] opcode
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [31:0] read_address, [63:32] physical_address,
                                           // [65:64] fault, [71:66] zero
  output logic             m_axis_tuser    // [0] kind
);

  // configuration registers
  logic        paging_on;
  logic [19:0] dir_base_frame;

  // walk state
  tlpw_pkg::phase_t phase, phase_next;
  logic [21:0]      pending_low_bits, pending_low_bits_next;

  // output register
  logic        out_valid;
  logic        out_kind;
  logic [31:0] out_read_address;
  logic [31:0] out_physical_address;
  logic [1:0]  out_fault;

  // decode of the current item
  logic        in_accept;
  logic        emit;
  logic        res_kind;
  logic [31:0] res_read_address;
  logic [31:0] res_physical_address;
  logic [1:0]  res_fault;
  logic [31:0] lin;
  logic [31:0] word;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign lin           = s_axis_tdata[31:0];
  assign word          = s_axis_tdata[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_on      <= 1'b0;
      dir_base_frame <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlpw_pkg::REG_PAGING_ON:      paging_on      <= cfg_data[0];
        tlpw_pkg::REG_DIR_BASE_FRAME: dir_base_frame <= cfg_data;
        default:                      paging_on      <= paging_on;
      endcase
    end
  end

  // Decode one item against the walk phase; only the present bit and frame are used.
  always_comb begin
    phase_next            = phase;
    pending_low_bits_next = pending_low_bits;
    emit                  = 1'b0;
    res_kind              = tlpw_pkg::KIND_DONE;
    res_read_address      = '0;
    res_physical_address  = '0;
    res_fault             = tlpw_pkg::FAULT_NONE;
    unique case (phase)
      tlpw_pkg::PHASE_DIR: begin
        if (s_axis_tuser == tlpw_pkg::OP_MEM_WORD) begin
          emit = 1'b1;
          if (!word[0]) begin
            phase_next = tlpw_pkg::PHASE_IDLE;
            res_fault  = tlpw_pkg::FAULT_DIR;
          end else begin
            phase_next       = tlpw_pkg::PHASE_TABLE;
            res_kind         = tlpw_pkg::KIND_READ;
            res_read_address = {word[31:12], pending_low_bits[21:12], 2'b00};
          end
        end
      end
      tlpw_pkg::PHASE_TABLE: begin
        if (s_axis_tuser == tlpw_pkg::OP_MEM_WORD) begin
          emit       = 1'b1;
          phase_next = tlpw_pkg::PHASE_IDLE;
          if (!word[0]) begin
            res_fault = tlpw_pkg::FAULT_TABLE;
          end else begin
            res_physical_address = {word[31:12], pending_low_bits[11:0]};
          end
        end
      end
      default: begin
        // idle, and any code that is not a walk phase
        phase_next = tlpw_pkg::PHASE_IDLE;
        if (s_axis_tuser == tlpw_pkg::OP_REQUEST) begin
          emit = 1'b1;
          if (!paging_on) begin
            res_physical_address = lin;
          end else begin
            phase_next            = tlpw_pkg::PHASE_DIR;
            pending_low_bits_next = lin[21:0];
            res_kind              = tlpw_pkg::KIND_READ;
            res_read_address      = {dir_base_frame, lin[31:22], 2'b00};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= tlpw_pkg::PHASE_IDLE;
      pending_low_bits <= '0;
    end else if (in_accept) begin
      phase            <= phase_next;
      pending_low_bits <= pending_low_bits_next;
    end
  end

  // Load the result on accept; drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_kind             <= res_kind;
      out_read_address     <= res_read_address;
      out_physical_address <= res_physical_address;
      out_fault            <= res_fault;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {6'b000000, out_fault, out_physical_address, out_read_address};

  // A read request never carries a fault or a physical address.
  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == tlpw_pkg::KIND_READ |->
      out_fault == tlpw_pkg::FAULT_NONE && out_physical_address == '0)
    else $error("read request item carries fault or physical address");

  // A finished translation never carries a read address.
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == tlpw_pkg::KIND_DONE |-> out_read_address == '0)
    else $error("finished item carries a read address");

  // A paged request taken while idle starts a directory read.
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_axis_tuser == tlpw_pkg::OP_REQUEST && phase == tlpw_pkg::PHASE_IDLE
      && paging_on |=> phase == tlpw_pkg::PHASE_DIR && out_valid
      && out_kind == tlpw_pkg::KIND_READ)
    else $error("paged request did not start a walk");

  // A memory word while idle leaves the phase idle and produces nothing.
  a_stray_word: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_axis_tuser == tlpw_pkg::OP_MEM_WORD && phase == tlpw_pkg::PHASE_IDLE
      |=> phase == tlpw_pkg::PHASE_IDLE && !out_valid)
    else $error("stray memory word changed state or produced an item");

endmodule

`default_nettype wire
